FILE: hdl/modular_exponentiation_core_macros.svh
// Assertion macros shared by the checker of the modular exponentiation core.
// Depends on nothing; the using module must declare clk and arst_n.
`ifndef MODULAR_EXPONENTIATION_CORE_MACROS_SVH
`define MODULAR_EXPONENTIATION_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define MXP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define MXP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/mxp_pkg.sv
// Package for the modular exponentiation core: field widths, constants,
// sequencer state type and the remainder unit status struct. No dependencies.
package mxp_pkg;

	localparam int unsigned BASE_W = 64;
	localparam int unsigned EXP_W  = 63;
	localparam int unsigned MOD_W  = 31;
	localparam int unsigned PROD_W = 2 * MOD_W;

	// Modulus after reset, and the smallest modulus that is in range.
	localparam logic [MOD_W-1:0] MOD_RESET = 31'd1000000007;
	localparam logic [MOD_W-1:0] MOD_MIN   = 31'd2;

	// Remainder unit: two dividend bits per step over a 64-bit dividend.
	localparam int unsigned RED_STEPS = BASE_W / 2;
	localparam int unsigned RED_CNT_W = $clog2(RED_STEPS);
	localparam logic [RED_CNT_W-1:0] RED_LAST = RED_CNT_W'(RED_STEPS - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BASE,
		ST_STEP,
		ST_MUL,
		ST_RSTART,
		ST_RWAIT,
		ST_FINISH
	} mxp_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mxp_red_status_t;

endpackage

FILE: hdl/mxp_ifs.sv
// Handshake channel interfaces of the modular exponentiation core.
// Depends on mxp_pkg for the field widths.
interface mxp_req_if;
	logic                           valid;
	logic                           ready;
	logic signed [mxp_pkg::BASE_W-1:0] base;
	logic [mxp_pkg::EXP_W-1:0]      exponent;

	modport source (output valid, output base, output exponent, input ready);
	modport sink (input valid, input base, input exponent, output ready);
endinterface

interface mxp_rsp_if;
	logic                      valid;
	logic                      ready;
	logic [mxp_pkg::MOD_W-1:0] power_result;

	modport source (output valid, output power_result, input ready);
	modport sink (input valid, input power_result, output ready);
endinterface

FILE: hdl/mxp_modred.sv
// Iterative remainder unit: reduces a 64-bit dividend modulo a 31-bit modulus,
// two dividend bits per cycle. Depends on mxp_pkg.
module mxp_modred (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [mxp_pkg::BASE_W-1:0]   dividend,
	input  logic [mxp_pkg::MOD_W-1:0]    modulus,
	output mxp_pkg::mxp_red_status_t     status,
	output logic [mxp_pkg::MOD_W-1:0]    remainder
);

	logic [mxp_pkg::BASE_W-1:0]    div_q;
	logic [mxp_pkg::MOD_W-1:0]     rem_q;
	logic [mxp_pkg::MOD_W-1:0]     m_q;
	logic [mxp_pkg::MOD_W+1:0]     m3_q;
	logic [mxp_pkg::RED_CNT_W-1:0] cnt_q;
	logic                          busy_q;
	logic                          done_q;

	logic [mxp_pkg::MOD_W+1:0] trial;
	logic [mxp_pkg::MOD_W+1:0] m1_ext;
	logic [mxp_pkg::MOD_W+1:0] m2_ext;
	logic [mxp_pkg::MOD_W+1:0] sub;
	logic [mxp_pkg::MOD_W+1:0] diff;

	// Shift two dividend bits into the partial remainder, which then lies
	// below four times the modulus; pick the largest multiple that fits.
	always_comb begin
		trial  = {rem_q, div_q[mxp_pkg::BASE_W-1 -: 2]};
		m1_ext = {2'b00, m_q};
		m2_ext = {1'b0, m_q, 1'b0};
		if (trial >= m3_q) begin
			sub = m3_q;
		end else if (trial >= m2_ext) begin
			sub = m2_ext;
		end else if (trial >= m1_ext) begin
			sub = m1_ext;
		end else begin
			sub = '0;
		end
		diff = trial - sub;
	end

	// Step counter and handshake flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == mxp_pkg::RED_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Dividend shift register, partial remainder and modulus multiples.
	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= dividend;
			rem_q <= '0;
			m_q   <= modulus;
			m3_q  <= {1'b0, modulus, 1'b0} + {2'b00, modulus};
		end else if (busy_q) begin
			div_q <= {div_q[mxp_pkg::BASE_W-3:0], 2'b00};
			rem_q <= diff[mxp_pkg::MOD_W-1:0];
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign remainder   = rem_q;

endmodule

FILE: hdl/modular_exponentiation_core.sv
// Modular exponentiation core: base to the power exponent modulo a programmable
// modulus by right-to-left square and multiply. One item is worked at a time and
// request.ready stays low until the result has been moved to the output register.
// A zero base, a zero exponent or a modulus below two goes straight to the finish state.
// Otherwise every modular multiplication is one pass of the shared remainder unit,
// which retires two dividend bits per cycle; the base reduction costs one such
// pass, each exponent bit up to the highest set bit costs one squaring plus one
// multiply when the bit is set, and the highest set bit costs only its multiply.
// A negative base is brought into range before use. The modulus register
// resets to 1000000007 and may only be written while no item is in flight.
// Depends on mxp_pkg, mxp_ifs.sv and mxp_modred.
module modular_exponentiation_core (
	input  logic                      clk,
	input  logic                      arst_n,
	mxp_req_if.sink                   request,
	mxp_rsp_if.source                 response,
	input  logic                      cfg_we,
	input  logic [mxp_pkg::MOD_W-1:0] cfg_wdata
);

	mxp_pkg::mxp_state_t state_q;
	mxp_pkg::mxp_state_t state_d;

	logic [mxp_pkg::MOD_W-1:0]  mod_q;
	logic [mxp_pkg::MOD_W-1:0]  m_q;
	logic                       neg_q;
	logic [mxp_pkg::EXP_W-1:0]  exp_q;
	logic [mxp_pkg::MOD_W-1:0]  base_q;
	logic [mxp_pkg::MOD_W-1:0]  res_q;
	logic                       op_sq_q;
	logic [mxp_pkg::PROD_W-1:0] prod_q;
	logic                       out_valid_q;
	logic [mxp_pkg::MOD_W-1:0]  out_data_q;

	logic [mxp_pkg::BASE_W-1:0] raw_u;
	logic [mxp_pkg::BASE_W-1:0] raw_mag;
	logic                       base_zero;
	logic                       mod_bad;
	logic                       trivial;
	logic [mxp_pkg::MOD_W-1:0]  mul_b;
	logic [mxp_pkg::PROD_W-1:0] mul_p;
	logic                       red_start;
	logic [mxp_pkg::BASE_W-1:0] red_dividend;
	logic [mxp_pkg::MOD_W-1:0]  red_rem;
	mxp_pkg::mxp_red_status_t   red_status;
	logic                       in_take;
	logic                       out_load;

	// Decode of the incoming item.
	always_comb begin
		raw_u     = request.base;
		raw_mag   = raw_u[mxp_pkg::BASE_W-1] ? (~raw_u + 64'd1) : raw_u;
		base_zero = (raw_u == '0);
		mod_bad   = (mod_q < mxp_pkg::MOD_MIN);
		trivial   = mod_bad || base_zero || (request.exponent == '0);
	end

	// Shared multiplier: either square the base or multiply it into the result.
	assign mul_b = op_sq_q ? base_q : res_q;
	assign mul_p = base_q * mul_b;

	assign red_dividend = (state_q == mxp_pkg::ST_IDLE) ? raw_mag
		: {{(mxp_pkg::BASE_W - mxp_pkg::PROD_W){1'b0}}, prod_q};

	mxp_modred u_modred (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (red_start),
		.dividend  (red_dividend),
		.modulus   ((state_q == mxp_pkg::ST_IDLE) ? mod_q : m_q),
		.status    (red_status),
		.remainder (red_rem)
	);

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mxp_pkg::ST_IDLE: begin
				if (request.valid) begin
					state_d = trivial ? mxp_pkg::ST_FINISH : mxp_pkg::ST_BASE;
				end
			end
			mxp_pkg::ST_BASE: begin
				if (red_status.done) begin
					state_d = mxp_pkg::ST_STEP;
				end
			end
			mxp_pkg::ST_STEP: begin
				state_d = (exp_q == '0) ? mxp_pkg::ST_FINISH : mxp_pkg::ST_MUL;
			end
			mxp_pkg::ST_MUL: begin
				state_d = mxp_pkg::ST_RSTART;
			end
			mxp_pkg::ST_RSTART: begin
				state_d = mxp_pkg::ST_RWAIT;
			end
			mxp_pkg::ST_RWAIT: begin
				if (red_status.done) begin
					if (op_sq_q) begin
						state_d = mxp_pkg::ST_STEP;
					end else if (exp_q[mxp_pkg::EXP_W-1:1] == '0) begin
						state_d = mxp_pkg::ST_FINISH;
					end else begin
						state_d = mxp_pkg::ST_MUL;
					end
				end
			end
			mxp_pkg::ST_FINISH: begin
				if (!out_valid_q || response.ready) begin
					state_d = mxp_pkg::ST_IDLE;
				end
			end
			default: state_d = mxp_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		request.ready = (state_q == mxp_pkg::ST_IDLE);
		in_take       = (state_q == mxp_pkg::ST_IDLE) && request.valid;
		red_start     = (in_take && !trivial) || (state_q == mxp_pkg::ST_RSTART);
		out_load      = (state_q == mxp_pkg::ST_FINISH) && (!out_valid_q || response.ready);
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mxp_pkg::ST_IDLE;
			mod_q       <= mxp_pkg::MOD_RESET;
			op_sq_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				mod_q <= cfg_wdata;
			end
			if (state_q == mxp_pkg::ST_STEP) begin
				op_sq_q <= !exp_q[0];
			end else if ((state_q == mxp_pkg::ST_RWAIT) && red_status.done) begin
				op_sq_q <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (response.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Operand, accumulator and product registers.
	always_ff @(posedge clk) begin
		if (in_take) begin
			m_q   <= mod_q;
			neg_q <= raw_u[mxp_pkg::BASE_W-1];
			exp_q <= request.exponent;
			res_q <= (mod_bad || base_zero) ? '0 : {{(mxp_pkg::MOD_W-1){1'b0}}, 1'b1};
		end
		if ((state_q == mxp_pkg::ST_BASE) && red_status.done) begin
			// A negative base maps to the modulus minus the magnitude's residue, or to zero if that residue is zero.
			base_q <= (neg_q && (red_rem != '0)) ? (m_q - red_rem) : red_rem;
			res_q  <= {{(mxp_pkg::MOD_W-1){1'b0}}, 1'b1};
		end
		if (state_q == mxp_pkg::ST_MUL) begin
			prod_q <= mul_p;
		end
		if ((state_q == mxp_pkg::ST_RWAIT) && red_status.done) begin
			if (op_sq_q) begin
				base_q <= red_rem;
				exp_q  <= {1'b0, exp_q[mxp_pkg::EXP_W-1:1]};
			end else begin
				res_q <= red_rem;
			end
		end
		if (out_load) begin
			out_data_q <= res_q;
		end
	end

	assign response.valid        = out_valid_q;
	assign response.power_result = out_data_q;

endmodule

FILE: hdl/mxp_checker.sv
// Port-level checker for the modular exponentiation core, bound to the top level.
// Depends on mxp_pkg and modular_exponentiation_core_macros.svh.
`include "modular_exponentiation_core_macros.svh"

module mxp_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      req_valid,
	input logic                      req_ready,
	input logic                      rsp_valid,
	input logic                      rsp_ready,
	input logic [mxp_pkg::MOD_W-1:0] power_result,
	input logic                      cfg_we,
	input logic [mxp_pkg::MOD_W-1:0] cfg_wdata
);

	logic [mxp_pkg::MOD_W-1:0] mod_shadow_q;
	logic [1:0]                pend_q;
	logic                      req_take;
	logic                      rsp_take;

	assign req_take = req_valid && req_ready;
	assign rsp_take = rsp_valid && rsp_ready;

	// Shadow of the modulus register and count of items not yet answered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_shadow_q <= mxp_pkg::MOD_RESET;
			pend_q       <= '0;
		end else begin
			if (cfg_we) begin
				mod_shadow_q <= cfg_wdata;
			end
			if (req_take && !rsp_take) begin
				pend_q <= pend_q + 1'b1;
			end else if (rsp_take && !req_take) begin
				pend_q <= pend_q - 1'b1;
			end
		end
	end

	// A result is a residue, or zero when the modulus is out of range.
	`MXP_ASSERT_NOW(a_result_range, rsp_valid, (power_result == '0) || (power_result < mod_shadow_q), "result not below modulus")

	// The block works on one item at a time.
	`MXP_ASSERT_NEXT(a_one_in_flight, req_take, !req_ready, "ready right after an accepted item")

	// Every result belongs to an accepted item.
	`MXP_ASSERT_NOW(a_no_spurious, rsp_valid, pend_q != 2'd0, "result without an accepted item")

	// A stalled result holds its value.
	`MXP_ASSERT_NEXT(a_result_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(power_result), "stalled result changed")

endmodule

bind modular_exponentiation_core mxp_checker u_mxp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (request.valid),
	.req_ready    (request.ready),
	.rsp_valid    (response.valid),
	.rsp_ready    (response.ready),
	.power_result (response.power_result),
	.cfg_we       (cfg_we),
	.cfg_wdata    (cfg_wdata)
);
